/* sv/rbe_pkg.sv */
// Shared types, register codes and fixed-point helpers for the rigid body step.
// No dependencies.
`default_nettype none
package rbe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DT_BITS   = 16;

  localparam logic [2:0] REG_MASS     = 3'd0;
  localparam logic [2:0] REG_FRICTION = 3'd1;
  localparam logic [2:0] REG_MAX_X    = 3'd2;
  localparam logic [2:0] REG_MAX_Y    = 3'd3;

  localparam logic signed [65:0] MAX32 = 66'sh0_7fff_ffff;
  localparam logic signed [65:0] MIN32 = -66'sh0_8000_0000;
  localparam logic signed [65:0] DT_RND = 66'sd65535;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] preset_accel_x;
    logic signed [31:0] preset_accel_y;
    logic signed [31:0] extra_accel_x;
    logic signed [31:0] extra_accel_y;
    logic [15:0]        delta_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
  } out_word_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > MAX32) return 32'sh7fff_ffff;
    if (x < MIN32) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // product over 2^16, rounded toward zero
  function automatic logic signed [65:0] trunc_dt(input logic signed [65:0] p);
    if (p < 0) return (p + DT_RND) >>> DT_BITS;
    return p >>> DT_BITS;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] x);
    if (x[31]) return ~{1'b1, x} + 33'd1;
    return {1'b0, x};
  endfunction

  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] q);
    if (!neg) return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    return (q > 64'h8000_0000) ? 32'h8000_0000 : ~q[31:0] + 32'd1;
  endfunction

endpackage
`default_nettype wire

/* sv/rbe_if.sv */
// Valid/ready channels for input and result words.
// Depends on rbe_pkg.
`default_nettype none
interface rbe_in_if import rbe_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbe_out_if import rbe_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/rigid_body_euler_step.sv */
// 2D rigid body step: semi-implicit Euler with kinetic friction, Q16.16.
// Depends on rbe_pkg and rbe_if.
//
// Usage: one input word on in_ch gives one result word on out_ch. The block
// keeps the velocity between words. Configuration (mass, friction, max speed
// per axis) must be written over cfg_we/cfg_index/cfg_data only while idle;
// the block itself leaves this unenforced. Unknown indexes are ignored.
// Work runs on a small sequencer around one 33x33 multiplier, a radix-2
// restoring divider and a digit-by-digit square root. The root and friction
// compare run only when the velocity is nonzero, the two divisions by mass
// only when the force is nonzero, and the two friction divisions only when
// friction does not stop the body. A new word is taken only after the
// previous result has left out_ch.
// in_ch.ready is high only while idle, one word at a time.
// The result is held in an output register until out_ch.ready; while the
// receiver stalls no new word is taken.
// Reset (rst, synchronous) clears velocity, loads mass 1.0, friction 0 and
// full max speeds, and empties the output.
`default_nettype none
module rigid_body_euler_step import rbe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rbe_in_if.sink           in_ch,
  rbe_out_if.source        out_ch
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_DIV   = 5'd2;
  localparam logic [4:0] S_DX_WB = 5'd3;
  localparam logic [4:0] S_DY_WB = 5'd4;
  localparam logic [4:0] S_ADD   = 5'd5;
  localparam logic [4:0] S_MAX   = 5'd6;
  localparam logic [4:0] S_MAY   = 5'd7;
  localparam logic [4:0] S_VY    = 5'd8;
  localparam logic [4:0] S_FR    = 5'd9;
  localparam logic [4:0] S_SQX   = 5'd10;
  localparam logic [4:0] S_SQY   = 5'd11;
  localparam logic [4:0] S_SQS   = 5'd12;
  localparam logic [4:0] S_SQRT  = 5'd13;
  localparam logic [4:0] S_CMP   = 5'd14;
  localparam logic [4:0] S_FX_LD = 5'd15;
  localparam logic [4:0] S_FX_WB = 5'd16;
  localparam logic [4:0] S_FY_LD = 5'd17;
  localparam logic [4:0] S_FY_WB = 5'd18;
  localparam logic [4:0] S_CLAMP = 5'd19;
  localparam logic [4:0] S_PX    = 5'd20;
  localparam logic [4:0] S_PY    = 5'd21;
  localparam logic [4:0] S_PD    = 5'd22;
  localparam logic [4:0] S_OUT   = 5'd23;

  logic [4:0]         state;
  logic [4:0]         ret;
  logic [31:0]        mass;
  logic [30:0]        fric;
  logic [30:0]        max_x;
  logic [30:0]        max_y;
  in_word_t           ld;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic [30:0]        fr;
  logic [63:0]        acc;
  logic [63:0]        sx;
  logic [63:0]        sr;
  logic [63:0]        sbit;
  logic [4:0]         scnt;
  logic [63:0]        dvd;
  logic [31:0]        rem;
  logic [31:0]        dsr;
  logic [5:0]         dcnt;
  logic signed [65:0] prod;
  out_word_t          odata;
  logic               ovalid;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [32:0]        div_t;
  logic               div_ge;
  logic [31:0]        rem_next;
  logic [63:0]        sq_trial;
  logic               sq_ge;
  logic signed [31:0] lim_x;
  logic signed [31:0] lim_y;
  logic               force_nz;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.data  = odata;
  assign force_nz     = (ld.force_x != 32'sd0) || (ld.force_y != 32'sd0);
  assign lim_x        = $signed({1'b0, max_x});
  assign lim_y        = $signed({1'b0, max_y});

  always_comb begin
    case (state)
      S_MAX:   begin mul_a = 33'(ax); mul_b = $signed({17'd0, ld.delta_time}); end
      S_MAY:   begin mul_a = 33'(ay); mul_b = $signed({17'd0, ld.delta_time}); end
      S_FR:    begin mul_a = $signed({2'b0, fric}); mul_b = $signed({17'd0, ld.delta_time}); end
      S_SQX:   begin mul_a = 33'(vx); mul_b = 33'(vx); end
      S_SQY:   begin mul_a = 33'(vy); mul_b = 33'(vy); end
      S_CMP:   begin mul_a = $signed(mag33(vx)); mul_b = $signed({2'b0, fr}); end
      S_FX_WB: begin mul_a = $signed(mag33(vy)); mul_b = $signed({2'b0, fr}); end
      S_PX:    begin mul_a = 33'(vx); mul_b = $signed({17'd0, ld.delta_time}); end
      S_PY:    begin mul_a = 33'(vy); mul_b = $signed({17'd0, ld.delta_time}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p    = mul_a * mul_b;
    div_t    = {rem, dvd[63]};
    div_ge   = (div_t >= {1'b0, dsr});
    rem_next = div_ge ? 32'(div_t - {1'b0, dsr}) : div_t[31:0];
    sq_trial = sr + sbit;
    sq_ge    = (sx >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      mass   <= 32'd1 << FRAC_BITS;
      fric   <= '0;
      max_x  <= '1;
      max_y  <= '1;
      vx     <= '0;
      vy     <= '0;
      ovalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MASS:     mass  <= cfg_data;
          REG_FRICTION: fric  <= cfg_data[30:0];
          REG_MAX_X:    max_x <= cfg_data[30:0];
          REG_MAX_Y:    max_y <= cfg_data[30:0];
          default:      ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            ld    <= in_ch.data;
            state <= S_START;
          end
        end
        S_START: begin
          if (force_nz) begin
            dvd   <= 64'(mag33(ld.force_x)) << FRAC_BITS;
            dsr   <= (mass == 32'd0) ? 32'd1 : mass;
            rem   <= '0;
            dcnt  <= '1;
            ret   <= S_DX_WB;
            state <= S_DIV;
          end else begin
            ax    <= ld.preset_accel_x;
            ay    <= ld.preset_accel_y;
            state <= S_ADD;
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[62:0], div_ge};
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) state <= ret;
        end
        S_DX_WB: begin
          ax    <= sat_mag(ld.force_x[31], dvd);
          dvd   <= 64'(mag33(ld.force_y)) << FRAC_BITS;
          rem   <= '0;
          dcnt  <= '1;
          ret   <= S_DY_WB;
          state <= S_DIV;
        end
        S_DY_WB: begin
          ay    <= sat_mag(ld.force_y[31], dvd);
          state <= S_ADD;
        end
        S_ADD: begin
          ax    <= sat32(66'(ax) + 66'(ld.extra_accel_x));
          ay    <= sat32(66'(ay) + 66'(ld.extra_accel_y));
          state <= S_MAX;
        end
        S_MAX: begin
          prod  <= mul_p;
          state <= S_MAY;
        end
        S_MAY: begin
          vx    <= sat32(66'(vx) + trunc_dt(prod));
          prod  <= mul_p;
          state <= S_VY;
        end
        S_VY: begin
          vy    <= sat32(66'(vy) + trunc_dt(prod));
          state <= S_FR;
        end
        S_FR: begin
          prod  <= mul_p;
          state <= S_SQX;
        end
        S_SQX: begin
          fr    <= prod[46:16];
          prod  <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          acc   <= prod[63:0];
          prod  <= mul_p;
          state <= S_SQS;
        end
        S_SQS: begin
          sx    <= acc + prod[63:0];
          sr    <= '0;
          sbit  <= 64'd1 << 62;
          scnt  <= '1;
          state <= ((vx == 32'sd0) && (vy == 32'sd0)) ? S_CLAMP : S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sx <= sx - sq_trial;
            sr <= (sr >> 1) + sbit;
          end else begin
            sr <= sr >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt - 5'd1;
          if (scnt == 5'd0) state <= S_CMP;
        end
        S_CMP: begin
          if (sr[31:0] <= {1'b0, fr}) begin
            vx    <= '0;
            vy    <= '0;
            state <= S_CLAMP;
          end else begin
            prod  <= mul_p;
            state <= S_FX_LD;
          end
        end
        S_FX_LD: begin
          dvd   <= prod[63:0];
          dsr   <= sr[31:0];
          rem   <= '0;
          dcnt  <= '1;
          ret   <= S_FX_WB;
          state <= S_DIV;
        end
        S_FX_WB: begin
          vx    <= vx[31] ? vx + $signed(dvd[31:0]) : vx - $signed(dvd[31:0]);
          prod  <= mul_p;
          state <= S_FY_LD;
        end
        S_FY_LD: begin
          dvd   <= prod[63:0];
          rem   <= '0;
          dcnt  <= '1;
          ret   <= S_FY_WB;
          state <= S_DIV;
        end
        S_FY_WB: begin
          vy    <= vy[31] ? vy + $signed(dvd[31:0]) : vy - $signed(dvd[31:0]);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          if (vx > lim_x) vx <= lim_x;
          else if (vx < -lim_x) vx <= -lim_x;
          if (vy > lim_y) vy <= lim_y;
          else if (vy < -lim_y) vy <= -lim_y;
          state <= S_PX;
        end
        S_PX: begin
          prod  <= mul_p;
          state <= S_PY;
        end
        S_PY: begin
          odata.new_pos_x <= sat32(66'(ld.pos_x) + trunc_dt(prod));
          prod            <= mul_p;
          state           <= S_PD;
        end
        S_PD: begin
          odata.new_pos_y <= sat32(66'(ld.pos_y) + trunc_dt(prod));
          odata.vel_out_x <= vx;
          odata.vel_out_y <= vy;
          ovalid          <= 1'b1;
          state           <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            ovalid <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_not_ready: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> !in_ch.ready) else $error("result pending while taking input");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("ready after accept");

  a_vel_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> $stable(vx) && $stable(vy)) else $error("velocity moved while idle");

  a_valid_only_out: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (state == S_OUT)) else $error("output valid outside output state");

endmodule
`default_nettype wire
